// ----- rtl/dfmhc_pkg.sv -----
// ----------------------------------------------------------------------------
// dfmhc_pkg
// Shared types and constants of the dragonfly minimal hop count block.
// ----------------------------------------------------------------------------
package dfmhc_pkg;

  localparam int ADDR_W     = 8;
  localparam int HOP_W      = 3;
  localparam int GC_W       = 9;
  localparam int LPGP_W     = 5;
  localparam int GPPR_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int PORT_W     = 32;
  localparam int BOUND_W    = ADDR_W + GPPR_W + 1;

  localparam int DEF_MAX_LINK_WEIGHT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINKS_PER_PAIR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GPORTS_PER_ROUTER = 2'd2;

  localparam logic [GC_W-1:0]   RST_GROUP_COUNT = 9'd9;
  localparam logic [LPGP_W-1:0] RST_LINKS_PER_PAIR = 5'd1;
  localparam logic [GPPR_W-1:0] RST_GPORTS_PER_ROUTER = 7'd4;

  localparam logic [HOP_W-1:0] HOP_SAME_ROUTER = 3'd1;
  localparam logic [HOP_W-1:0] HOP_SAME_GROUP = 3'd2;
  localparam logic [HOP_W-1:0] HOP_GLOBAL_BASE = 3'd2;
  localparam logic [HOP_W-1:0] HOP_WORST = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
  } dp_stat_t;

endpackage

// ----- rtl/dfmhc_ctrl.sv -----
// ----------------------------------------------------------------------------
// dfmhc_ctrl
// Controller: accepts an item, sequences the link weight loop, holds the
// result until it is taken.
// ----------------------------------------------------------------------------
module dfmhc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dfmhc_pkg::dp_stat_t stat,
  output dfmhc_pkg::ctl_cmd_t cmd
);
  import dfmhc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOP = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.skip ? S_DONE : S_LOOP;
        end
      end
      S_LOOP: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/dfmhc_dpath.sv -----
// ----------------------------------------------------------------------------
// dfmhc_dpath
// Datapath: global port accumulators, router bound compare and running
// minimum of the hop count.
// ----------------------------------------------------------------------------
module dfmhc_dpath #(
  parameter int MAX_LINK_WEIGHT = dfmhc_pkg::DEF_MAX_LINK_WEIGHT
) (
  input  logic                              clk,
  input  logic [dfmhc_pkg::ADDR_W-1:0]      src_router,
  input  logic [dfmhc_pkg::ADDR_W-1:0]      src_group,
  input  logic [dfmhc_pkg::ADDR_W-1:0]      dst_router,
  input  logic [dfmhc_pkg::ADDR_W-1:0]      dst_group,
  input  logic [dfmhc_pkg::GC_W-1:0]        group_count,
  input  logic [dfmhc_pkg::LPGP_W-1:0]      links_per_group_pair,
  input  logic [dfmhc_pkg::GPPR_W-1:0]      global_ports_per_router,
  input  dfmhc_pkg::ctl_cmd_t               cmd,
  output dfmhc_pkg::dp_stat_t               stat,
  output logic [dfmhc_pkg::HOP_W-1:0]       hop_count
);
  import dfmhc_pkg::*;

  localparam int LIM_W = $clog2(MAX_LINK_WEIGHT + 1);

  logic [PORT_W-1:0]  port_src, port_dst;
  logic [BOUND_W-1:0] lo_src, hi_src, lo_dst, hi_dst;
  logic [LIM_W-1:0]   cnt;
  logic [HOP_W-1:0]   best;

  logic [LIM_W-1:0]  limit;
  logic [PORT_W-1:0] gc_ext, step_amt, fwd, rev;
  logic [BOUND_W-1:0] lo_src_in, lo_dst_in;
  logic              no_ports, miss_src, miss_dst;
  logic [HOP_W-1:0]  hops;

  always_comb begin
    if (32'(links_per_group_pair) > 32'(MAX_LINK_WEIGHT)) begin
      limit = LIM_W'(MAX_LINK_WEIGHT);
    end else begin
      limit = LIM_W'(links_per_group_pair);
    end
  end

  assign gc_ext   = PORT_W'(group_count);
  assign step_amt = gc_ext - PORT_W'(1);
  // forward and reverse group offsets, wrapping 32-bit arithmetic
  assign fwd = (dst_group < src_group) ?
               (PORT_W'(dst_group) + gc_ext) - PORT_W'(src_group) :
               PORT_W'(dst_group) - PORT_W'(src_group);
  assign rev = gc_ext - fwd;

  assign lo_src_in = BOUND_W'(src_router) * BOUND_W'(global_ports_per_router);
  assign lo_dst_in = BOUND_W'(dst_router) * BOUND_W'(global_ports_per_router);

  assign stat.skip = (src_group == dst_group) || (limit == '0);
  assign stat.last = ({1'b0, cnt} + (LIM_W+1)'(1)) == {1'b0, limit};

  // router == port / gppr  iff  router*gppr <= port < (router+1)*gppr
  assign no_ports = (global_ports_per_router == '0);
  assign miss_src = no_ports || (port_src < PORT_W'(lo_src)) ||
                    (port_src >= PORT_W'(hi_src));
  assign miss_dst = no_ports || (port_dst < PORT_W'(lo_dst)) ||
                    (port_dst >= PORT_W'(hi_dst));
  assign hops = HOP_GLOBAL_BASE + HOP_W'(miss_src) + HOP_W'(miss_dst);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      port_src <= fwd - PORT_W'(1);
      port_dst <= rev - PORT_W'(1);
      lo_src   <= lo_src_in;
      hi_src   <= lo_src_in + BOUND_W'(global_ports_per_router);
      lo_dst   <= lo_dst_in;
      hi_dst   <= lo_dst_in + BOUND_W'(global_ports_per_router);
      cnt      <= '0;
      if (src_group == dst_group) begin
        best <= (src_router == dst_router) ? HOP_SAME_ROUTER : HOP_SAME_GROUP;
      end else begin
        best <= HOP_WORST;
      end
    end else if (cmd.step) begin
      port_src <= port_src + step_amt;
      port_dst <= port_dst + step_amt;
      cnt      <= cnt + LIM_W'(1);
      if (hops < best) begin
        best <= hops;
      end
    end
  end

  assign hop_count = best;

endmodule

// ----- rtl/dragonfly_minimal_hop_count_top.sv -----
// ----------------------------------------------------------------------------
// dragonfly_minimal_hop_count_top
// Minimal router hop count between two dragonfly router addresses.
// ----------------------------------------------------------------------------
// result: valid in the cycle after accept for same group or zero weight,
//   else after min(links_per_group_pair, MAX_LINK_WEIGHT) weights are tried
// throughput: a new item is taken only once the result is taken; the weight
//   loop tries one global link weight per cycle on a single compare unit
// reset: configuration registers return to 9, 1, 4; block idle, ready high
module dragonfly_minimal_hop_count_top #(
  parameter int MAX_LINK_WEIGHT = dfmhc_pkg::DEF_MAX_LINK_WEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dfmhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfmhc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dfmhc_pkg::ADDR_W-1:0]       src_router,
  input  logic [dfmhc_pkg::ADDR_W-1:0]       src_group,
  input  logic [dfmhc_pkg::ADDR_W-1:0]       dst_router,
  input  logic [dfmhc_pkg::ADDR_W-1:0]       dst_group,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dfmhc_pkg::HOP_W-1:0]        hop_count
);
  import dfmhc_pkg::*;

  logic [GC_W-1:0]   group_count;
  logic [LPGP_W-1:0] links_per_group_pair;
  logic [GPPR_W-1:0] global_ports_per_router;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count             <= RST_GROUP_COUNT;
      links_per_group_pair    <= RST_LINKS_PER_PAIR;
      global_ports_per_router <= RST_GPORTS_PER_ROUTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_COUNT:       group_count <= cfg_data[GC_W-1:0];
        REG_LINKS_PER_PAIR:    links_per_group_pair <= cfg_data[LPGP_W-1:0];
        REG_GPORTS_PER_ROUTER: global_ports_per_router <= cfg_data[GPPR_W-1:0];
        default: ;
      endcase
    end
  end

  dfmhc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dfmhc_dpath #(
    .MAX_LINK_WEIGHT (MAX_LINK_WEIGHT)
  ) u_dpath (
    .clk                     (clk),
    .src_router              (src_router),
    .src_group               (src_group),
    .dst_router              (dst_router),
    .dst_group               (dst_group),
    .group_count             (group_count),
    .links_per_group_pair    (links_per_group_pair),
    .global_ports_per_router (global_ports_per_router),
    .cmd                     (cmd),
    .stat                    (stat),
    .hop_count               (hop_count)
  );

endmodule
